[rtl/core/sha256_pkg.sv]
// SHA-256 stream hasher package: item kinds, round constants, initial hash.
// Used by the front, back and top-level modules; no dependencies.
package sha256_pkg;

  localparam int KIND_W  = 2;
  localparam int QDEPTH  = 4;

  localparam logic [KIND_W-1:0] KIND_BYTE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LAST = 2'd1;
  localparam logic [KIND_W-1:0] KIND_END  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_RSVD = 2'd3;

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [9:0] BLOCK_BITS = 10'd512;

  // Queue entry: a byte to store and/or an end-of-message request
  typedef struct packed {
    logic       has_byte;
    logic       fin;
    logic [7:0] data;
  } q_item_t;

  function automatic logic [31:0] round_k(input logic [5:0] i);
    logic [31:0] k;
    case (i)
      6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
      6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
      6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

  function automatic logic [31:0] init_hash(input logic [2:0] i);
    logic [31:0] h;
    case (i)
      3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
      3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
      3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
      3'd6: h = 32'h1f83d9ab; default: h = 32'h5be0cd19;
    endcase
    return h;
  endfunction

  function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
    return (v >> n) | (v << (32 - n));
  endfunction

endpackage

[rtl/core/sha256_front.sv]
// Front end: classifies input transactions and queues byte/end requests.
// Depends on sha256_pkg.
module sha256_front #(
  parameter int QDepth = sha256_pkg::QDEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [7:0]           in_tdata,
  input  logic [1:0]           in_tuser,
  output logic                 q_valid,
  input  logic                 q_ready,
  output sha256_pkg::q_item_t  q_item
);
  import sha256_pkg::*;

  localparam int AW = (QDepth > 1) ? $clog2(QDepth) : 1;

  q_item_t           mem_r [QDepth];
  logic [AW-1:0]     wp_r, wp_nxt, rp_r, rp_nxt;
  logic [AW:0]       cnt_r, cnt_nxt;
  logic              push, pop;
  q_item_t           cls;

  // Classify the incoming kind
  always_comb begin
    cls.data     = in_tdata;
    cls.has_byte = 1'b0;
    cls.fin      = 1'b0;
    unique case (in_tuser)
      KIND_BYTE: cls.has_byte = 1'b1;
      KIND_LAST: begin cls.has_byte = 1'b1; cls.fin = 1'b1; end
      KIND_END:  cls.fin = 1'b1;
      default:   ;
    endcase
  end

  assign in_tready = (cnt_r != (AW+1)'(QDepth));
  // Unused kind is consumed without queueing
  assign push   = in_tvalid && in_tready && (cls.has_byte || cls.fin);
  assign q_valid = (cnt_r != '0);
  assign pop    = q_valid && q_ready;
  assign q_item = mem_r[rp_r];

  always_comb begin
    wp_nxt  = push ? ((wp_r == AW'(QDepth-1)) ? '0 : wp_r + 1'b1) : wp_r;
    rp_nxt  = pop  ? ((rp_r == AW'(QDepth-1)) ? '0 : rp_r + 1'b1) : rp_r;
    cnt_nxt = cnt_r + (AW+1)'(push) - (AW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      wp_r <= wp_nxt; rp_r <= rp_nxt; cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= cls;
  end

endmodule

[rtl/core/sha256_back.sv]
// Back end: block buffer, padding, 64-round compression and digest output.
// Depends on sha256_pkg.
module sha256_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  output logic                 q_ready,
  input  sha256_pkg::q_item_t  q_item,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [31:0]          out_tdata,
  output logic [2:0]           out_tuser,
  output logic                 out_tlast
);
  import sha256_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_PAD  = 3'd1;
  localparam logic [2:0] ST_LEN  = 3'd2;
  localparam logic [2:0] ST_COMP = 3'd3;
  localparam logic [2:0] ST_ADD  = 3'd4;
  localparam logic [2:0] ST_OUT  = 3'd5;

  logic [2:0]  st_r, st_nxt;
  logic [31:0] w_r [16];       // 16-word schedule window, filled with block bytes
  logic [31:0] h_r [8];
  logic [31:0] s_r [8];
  logic [5:0]  fill_r;         // byte position in block
  logic [63:0] bits_r;         // bits absorbed into full blocks
  logic [63:0] len_r;          // latched message length for padding
  logic [5:0]  rnd_r;
  logic        fin_r;          // current compression carries the length
  logic        end_r;          // message end in progress
  logic        pad_r;          // 0x80 pad byte still to be written
  logic [2:0]  oidx_r;
  logic        bput;
  logic [7:0]  bval;
  logic [31:0] wt, t1, t2, wnew, s0, s1;

  assign q_ready = (st_r == ST_IDLE);

  // Byte write source: queue byte, pad, zero or length byte
  always_comb begin
    bput = 1'b0;
    bval = q_item.data;
    unique case (st_r)
      ST_IDLE: bput = q_valid && q_item.has_byte;
      ST_PAD:  begin bput = 1'b1; bval = pad_r ? PAD_BYTE : 8'h00; end
      ST_LEN:  begin bput = 1'b1; bval = len_r[63:56]; end
      default: ;
    endcase
  end

  // Round datapath
  assign wt = w_r[0];
  assign s0 = rotr(w_r[1], 7) ^ rotr(w_r[1], 18) ^ (w_r[1] >> 3);
  assign s1 = rotr(w_r[14], 17) ^ rotr(w_r[14], 19) ^ (w_r[14] >> 10);
  assign wnew = s1 + w_r[9] + s0 + w_r[0];
  assign t1 = s_r[7] + (rotr(s_r[4], 6) ^ rotr(s_r[4], 11) ^ rotr(s_r[4], 25))
            + ((s_r[4] & s_r[5]) ^ (~s_r[4] & s_r[6])) + round_k(rnd_r) + wt;
  assign t2 = (rotr(s_r[0], 2) ^ rotr(s_r[0], 13) ^ rotr(s_r[0], 22))
            + ((s_r[0] & s_r[1]) ^ (s_r[0] & s_r[2]) ^ (s_r[1] & s_r[2]));

  // Padding runs to position 55 and then the length, or to 63 first when the
  // message end leaves no room for the length in the current block
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE: if (q_valid) begin
        if (q_item.has_byte && fill_r == 6'd63) st_nxt = ST_COMP;
        else if (q_item.fin) st_nxt = ST_PAD;
      end
      ST_PAD:  if (fill_r == 6'd55) st_nxt = ST_LEN;
               else if (fill_r == 6'd63) st_nxt = ST_COMP;
      ST_LEN:  if (fill_r == 6'd63) st_nxt = ST_COMP;
      ST_COMP: if (rnd_r == 6'd63) st_nxt = ST_ADD;
      ST_ADD:  begin
        if (fin_r) st_nxt = ST_OUT;
        else if (end_r) st_nxt = ST_PAD;
        else st_nxt = ST_IDLE;
      end
      ST_OUT:  if (out_tready && oidx_r == 3'd7) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE; fill_r <= '0; bits_r <= '0; rnd_r <= '0;
      fin_r <= 1'b0; end_r <= 1'b0; pad_r <= 1'b0;
      oidx_r <= '0; out_tvalid <= 1'b0;
      for (int i = 0; i < 8; i++) h_r[i] <= init_hash(3'(i));
    end else begin
      st_r <= st_nxt;
      // Bytes enter word 15; a completed word moves down as the next one starts
      if (bput) begin
        w_r[15] <= {w_r[15][23:0], bval};
        if (fill_r[1:0] == 2'd0)
          for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
        fill_r <= fill_r + 6'd1;
      end
      unique case (st_r)
        ST_IDLE: if (q_valid) begin
          if (q_item.fin) begin
            len_r <= bits_r + {55'd0, fill_r, 3'd0}
                   + (q_item.has_byte ? 64'd8 : 64'd0);
            end_r <= 1'b1;
            pad_r <= 1'b1;
          end
          if (q_item.has_byte && fill_r == 6'd63) begin
            bits_r <= bits_r + 64'(BLOCK_BITS);
            for (int i = 0; i < 8; i++) s_r[i] <= h_r[i];
            rnd_r <= '0;
          end
        end
        ST_PAD: begin
          pad_r <= 1'b0;
          if (fill_r == 6'd63) begin
            for (int i = 0; i < 8; i++) s_r[i] <= h_r[i];
            rnd_r <= '0;
          end
        end
        ST_LEN: begin
          len_r <= {len_r[55:0], 8'h00};
          if (fill_r == 6'd63) begin
            for (int i = 0; i < 8; i++) s_r[i] <= h_r[i];
            rnd_r <= '0;
            fin_r <= 1'b1;
          end
        end
        ST_COMP: begin
          for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
          w_r[15] <= wnew;
          s_r[7] <= s_r[6]; s_r[6] <= s_r[5]; s_r[5] <= s_r[4];
          s_r[4] <= s_r[3] + t1;
          s_r[3] <= s_r[2]; s_r[2] <= s_r[1]; s_r[1] <= s_r[0];
          s_r[0] <= t1 + t2;
          rnd_r <= rnd_r + 6'd1;
        end
        ST_ADD: begin
          for (int i = 0; i < 8; i++) h_r[i] <= h_r[i] + s_r[i];
          if (fin_r) begin out_tvalid <= 1'b1; oidx_r <= '0; end
        end
        ST_OUT: if (out_tready) begin
          oidx_r <= oidx_r + 3'd1;
          if (oidx_r == 3'd7) begin
            out_tvalid <= 1'b0;
            for (int i = 0; i < 8; i++) h_r[i] <= init_hash(3'(i));
            bits_r <= '0; fin_r <= 1'b0; end_r <= 1'b0;
          end else begin
            for (int i = 0; i < 7; i++) h_r[i] <= h_r[i+1];
          end
        end
        default: ;
      endcase
    end
  end

  assign out_tdata = h_r[0];
  assign out_tuser = oidx_r;
  assign out_tlast = (oidx_r == 3'd7);

endmodule

[rtl/core/sha256_stream_hasher_core.sv]
// Top level of the SHA-256 stream hasher: front queue plus compression back end.
// Depends on sha256_pkg, sha256_front, sha256_back.
//
//  channel | dir | tdata                 | tuser                  | tlast
//  in_     | in  | [7:0] msg_byte        | [1:0] kind             | -
//  out_    | out | [31:0] digest_word    | [2:0] word_index       | last_word
//
// The back end takes one byte per cycle; a full block then runs the 64 rounds and
// the hash add, during which input stalls once the QDepth-entry queue fills.
// Message end writes one pad/length byte per cycle up to the block end, runs one or
// two compressions, and sends eight output words, each held while out_tready
// is low. Reset is synchronous and restores the initial hash.
module sha256_stream_hasher_core #(
  parameter int QDepth = sha256_pkg::QDEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] msg_byte
  input  logic [1:0]  in_tuser,   // [1:0] kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] digest_word
  output logic [2:0]  out_tuser,  // [2:0] word_index
  output logic        out_tlast
);
  import sha256_pkg::*;

  logic    q_valid, q_ready;
  q_item_t q_item;

  sha256_front #(.QDepth(QDepth)) u_front (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .q_valid, .q_ready, .q_item
  );

  sha256_back u_back (
    .clk, .rst_n, .q_valid, .q_ready, .q_item,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser, .out_tlast
  );

`ifndef SYNTH
  a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tuser == 3'd7) else $error("tlast index");
  a_word_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=> out_tvalid) else $error("digest gap");
`endif

endmodule
